@@ rtl/core/mrr_pkg.sv @@
// mrr_pkg: shared types for the Miller-Rabin round block.
// Holds the command and status groups between controller and datapath.
// No dependencies.
package mrr_pkg;

  typedef struct packed {
    logic load;
    logic prep;
    logic norm_step;
    logic div_step;
    logic base_set;
    logic mul_start;
    logic mul_sel_base;
    logic mul_step;
    logic mul_done;
    logic exp_shift;
  } mrr_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_even;
    logic n_is_two;
    logic odd_lsb;
    logic exp_msb;
    logic x_is_one;
    logic x_is_nm1;
  } mrr_stat_t;

  localparam int unsigned InFieldBits = 64;
  localparam int unsigned OutDataBits = 8;

endpackage

@@ rtl/core/mrr_dp.sv @@
// mrr_dp: datapath of the Miller-Rabin round.
// Seed reduction by n-1 (restoring, one bit a cycle), odd-part extraction,
// and a bit-serial shift-add modular multiplier. Depends on mrr_pkg.
module mrr_dp #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                   clk,
  input  logic [WORD_BITS-1:0]   number,
  input  logic [WORD_BITS-1:0]   witness_seed,
  input  mrr_pkg::mrr_cmd_t      cmd,
  output mrr_pkg::mrr_stat_t     stat
);
  import mrr_pkg::*;

  localparam int unsigned W = WORD_BITS;

  logic [W-1:0] n;
  logic [W-1:0] nm1;
  logic [W-1:0] seed_sh;
  logic [W-1:0] rem;
  logic [W-1:0] expo;
  logic [W-1:0] base;
  logic [W-1:0] x;
  logic [W-1:0] acc;
  logic [W-1:0] yy;
  logic [W-1:0] xx;

  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;
  logic [W-1:0] acc_add;
  logic [W-1:0] yy_dbl;

  // (a + b) mod m for a, b < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                           input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W-1:0] room;
    begin
      room = m - b;
      add_mod = (a >= room) ? (a - room) : (a + b);
    end
  endfunction

  always_comb begin
    rem_sh  = {rem, seed_sh[W-1]};
    rem_sub = rem_sh - {1'b0, nm1};
    acc_add = add_mod(acc, yy, n);
    yy_dbl  = add_mod(yy, yy, n);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= number;
      seed_sh <= witness_seed;
    end
    if (cmd.prep) begin
      nm1  <= n - W'(1);
      expo <= n - W'(1);
      rem  <= '0;
    end
    if (cmd.norm_step) begin
      expo <= expo >> 1;
    end
    if (cmd.div_step) begin
      seed_sh <= seed_sh << 1;
      if (rem_sh >= {1'b0, nm1}) begin
        rem <= rem_sub[W-1:0];
      end else begin
        rem <= rem_sh[W-1:0];
      end
    end
    if (cmd.base_set) begin
      base <= rem + W'(1);
      x    <= W'(1);
    end
    if (cmd.exp_shift) begin
      expo <= expo << 1;
    end
    if (cmd.mul_start) begin
      acc <= '0;
      xx  <= x;
      yy  <= cmd.mul_sel_base ? base : x;
    end
    if (cmd.mul_step) begin
      if (xx[0]) begin
        acc <= acc_add;
      end
      yy <= yy_dbl;
      xx <= xx >> 1;
    end
    if (cmd.mul_done) begin
      x <= acc;
    end
  end

  always_comb begin
    stat.n_lt2    = (n < W'(2));
    stat.n_even   = ~n[0];
    stat.n_is_two = (n == W'(2));
    stat.odd_lsb  = expo[0];
    stat.exp_msb  = expo[W-1];
    stat.x_is_one = (x == W'(1));
    stat.x_is_nm1 = (x == nm1);
  end

endmodule

@@ rtl/core/mrr_ctrl.sv @@
// mrr_ctrl: controller of the Miller-Rabin round.
// Sequences classification, seed reduction, exponentiation and the final
// squarings, and holds the result register. Depends on mrr_pkg.
module mrr_ctrl #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mrr_pkg::OutDataBits-1:0]   m_tdata,
  output mrr_pkg::mrr_cmd_t                 cmd,
  input  mrr_pkg::mrr_stat_t                stat
);
  import mrr_pkg::*;

  localparam int unsigned CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LastStep = CW'(WORD_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_NORM,
    S_DIV,
    S_BASE,
    S_NEXT,
    S_MUL_RUN,
    S_MUL_END,
    S_CHECK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_FIRST,
    K_SQ,
    K_BASE,
    K_TAIL
  } kind_t;

  state_t        state;
  kind_t         kind;
  logic [CW-1:0] cnt;
  logic [CW-1:0] twos;
  logic [CW-1:0] ebit;
  logic          verdict;

  logic tail_more;
  assign tail_more = (twos >= CW'(2));

  always_comb begin
    cmd      = '0;
    s_tready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = s_tvalid;
      end
      S_CLASSIFY: begin
        cmd.prep = ~stat.n_lt2 & ~stat.n_even;
      end
      S_NORM: begin
        cmd.norm_step = ~stat.odd_lsb;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_BASE: begin
        cmd.base_set = 1'b1;
      end
      S_NEXT: begin
        case (kind)
          K_FIRST: begin
            cmd.mul_start = 1'b1;
          end
          K_SQ: begin
            if (stat.exp_msb) begin
              cmd.mul_start    = 1'b1;
              cmd.mul_sel_base = 1'b1;
            end else begin
              cmd.exp_shift = 1'b1;
              cmd.mul_start = (ebit != LastStep);
            end
          end
          K_BASE: begin
            cmd.exp_shift = 1'b1;
            cmd.mul_start = (ebit != LastStep);
          end
          K_TAIL: begin
            cmd.mul_start = ~stat.x_is_nm1 & tail_more;
          end
          default: begin
            cmd.mul_start = 1'b0;
          end
        endcase
      end
      S_MUL_RUN: begin
        cmd.mul_step = 1'b1;
      end
      S_MUL_END: begin
        cmd.mul_done = 1'b1;
      end
      S_CHECK: begin
        cmd.mul_start = ~stat.x_is_one & ~stat.x_is_nm1 & tail_more;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      kind     <= K_FIRST;
      cnt      <= '0;
      twos     <= '0;
      ebit     <= '0;
      verdict  <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CLASSIFY;
          end
        end
        S_CLASSIFY: begin
          twos <= '0;
          if (stat.n_lt2) begin
            verdict <= 1'b0;
            state   <= S_DONE;
          end else if (stat.n_even) begin
            verdict <= stat.n_is_two;
            state   <= S_DONE;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!stat.odd_lsb) begin
            twos <= twos + CW'(1);
          end else begin
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + CW'(1);
          if (cnt == LastStep) begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          kind  <= K_FIRST;
          ebit  <= '0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          cnt <= '0;
          case (kind)
            K_FIRST: begin
              kind  <= K_SQ;
              state <= S_MUL_RUN;
            end
            K_SQ: begin
              if (stat.exp_msb) begin
                kind  <= K_BASE;
                state <= S_MUL_RUN;
              end else if (ebit == LastStep) begin
                state <= S_CHECK;
              end else begin
                ebit  <= ebit + CW'(1);
                state <= S_MUL_RUN;
              end
            end
            K_BASE: begin
              if (ebit == LastStep) begin
                state <= S_CHECK;
              end else begin
                ebit  <= ebit + CW'(1);
                kind  <= K_SQ;
                state <= S_MUL_RUN;
              end
            end
            K_TAIL: begin
              if (stat.x_is_nm1) begin
                verdict <= 1'b1;
                state   <= S_DONE;
              end else if (!tail_more) begin
                verdict <= 1'b0;
                state   <= S_DONE;
              end else begin
                twos  <= twos - CW'(1);
                state <= S_MUL_RUN;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_MUL_RUN: begin
          cnt <= cnt + CW'(1);
          if (cnt == LastStep) begin
            state <= S_MUL_END;
          end
        end
        S_MUL_END: begin
          state <= S_NEXT;
        end
        S_CHECK: begin
          cnt <= '0;
          if (stat.x_is_one || stat.x_is_nm1) begin
            verdict <= 1'b1;
            state   <= S_DONE;
          end else if (!tail_more) begin
            verdict <= 1'b0;
            state   <= S_DONE;
          end else begin
            twos  <= twos - CW'(1);
            kind  <= K_TAIL;
            state <= S_MUL_RUN;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OutDataBits-1){1'b0}}, verdict};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/miller_rabin_round.sv @@
// miller_rabin_round: top level of one Miller-Rabin primality round.
// Instantiates mrr_ctrl and mrr_dp; depends on mrr_pkg.
//
// One transfer in gives one verdict out. Odd candidates of 3 and up run
// W squarings, W = WORD_BITS, one product per set bit of the odd part of
// n-1 and up to s-1 closing squarings, s = trailing zeros of n-1. Each
// product runs on the bit-serial shift-add multiplier; 0, 1 and even
// numbers are decided at classification with no products. One candidate
// is worked at a time; the next one is taken while a verdict still waits
// in the output register.
module miller_rabin_round #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [63:0] number, [127:64] witness_seed
  input  logic [2*mrr_pkg::InFieldBits-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] probably_prime, [7:1] zero
  output logic [mrr_pkg::OutDataBits-1:0]     m_tdata
);
  import mrr_pkg::*;

  mrr_cmd_t  cmd;
  mrr_stat_t stat;

  logic [WORD_BITS-1:0] number;
  logic [WORD_BITS-1:0] witness_seed;

  assign number       = s_tdata[WORD_BITS-1:0];
  assign witness_seed = s_tdata[InFieldBits +: WORD_BITS];

  mrr_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  mrr_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .number       (number),
    .witness_seed (witness_seed),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
